>>> rtl/core/pps_pkg.sv
// Package for the promotable priority store: field widths, item kinds,
// status codes and the command/status structs between controller and datapath.
// No dependencies.
package pps_pkg;

    // Default sizing, used as the defaults of the top level parameters
    localparam int DEF_CAPACITY     = 16;
    localparam int DEF_PAYLOAD_BITS = 32;
    localparam int DEF_IDENT_BITS   = 32;

    // Fixed port field widths
    localparam int FIELD_W   = 32;
    localparam int KIND_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int RANK_BITS = 32;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_ADD      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PROMOTE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_GET_MAX  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_MAX  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_IS_VALID = 3'd4;
    localparam logic [KIND_W-1:0] KIND_GET      = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_UNKNOWN = 2'd3;

    // Controller -> datapath commands
    typedef struct packed {
        logic clear_step;  // write one used bit to zero, advance counter
        logic load;        // capture input item, reset scan trackers
        logic scan_step;   // read one slot, advance counter
        logic commit;      // apply update, load output register
    } pps_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic cnt_last;    // slot counter at the last slot
        logic out_free;    // output register can take a result this cycle
    } pps_stat_t;

endpackage

>>> rtl/core/promotable_priority_store.sv
// Promotable priority store, top level: controller plus datapath.
// Depends on pps_pkg, pps_ctrl and pps_datapath.
//
// Usage:
//   s_ channel takes one item (kind, entry_id, payload); m_ channel returns
//   exactly one result (status, found, id, payload, priority) per item.
//   Both channels are valid/ready; an item moves when both are high.
//   Every item scans all CAPACITY slots, one slot read per cycle from the
//   slot memory's single read port. The result becomes valid after the scan,
//   at commit, and the next item is taken only after that commit.
//   Reset (aresetn low, synchronous) empties the store and zeroes the
//   identifier counter. After reset a clearing pass over all CAPACITY slots
//   zeroes the used bits; s_ready stays low during it.
//   The result sits in an output register. A new item can be accepted
//   while it waits; if m_ready is still low when the next result is ready,
//   the block holds that result internally and keeps s_ready low.
module promotable_priority_store
    import pps_pkg::*;
#(
    parameter int CAPACITY     = DEF_CAPACITY,
    parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS,
    parameter int IDENT_BITS   = DEF_IDENT_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [KIND_W-1:0]   s_kind,
    input  logic [FIELD_W-1:0]  s_entry_id,
    input  logic [FIELD_W-1:0]  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic                m_found,
    output logic [FIELD_W-1:0]  m_result_id,
    output logic [FIELD_W-1:0]  m_result_payload,
    output logic [FIELD_W-1:0]  m_result_priority
);

    pps_cmd_t  cmd;
    pps_stat_t stat;

    pps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pps_datapath #(
        .CAPACITY     (CAPACITY),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .IDENT_BITS   (IDENT_BITS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .s_kind            (s_kind),
        .s_entry_id        (s_entry_id),
        .s_payload         (s_payload),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_found           (m_found),
        .m_result_id       (m_result_id),
        .m_result_payload  (m_result_payload),
        .m_result_priority (m_result_priority)
    );

`ifndef SYNTHESIS
    // One item at a time: no item right after an accepted one
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item accepted while another is in flight");

    // A commit always presents a result next cycle
    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid)
        else $error("commit did not raise m_valid");

    // Commit never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid || m_ready))
        else $error("commit overwrote a pending result");

    // Flagged results carry no entry
    a_flag_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == STAT_EMPTY || m_status == STAT_FULL ||
                     m_status == STAT_UNKNOWN)) |-> (!m_found && m_result_id == '0))
        else $error("flagged result reports an entry");
`endif

endmodule

>>> rtl/core/pps_ctrl.sv
// Controller for the promotable priority store: one-hot state machine that
// sequences the clearing pass, the slot scan and the commit.
// Depends on pps_pkg.
module pps_ctrl
    import pps_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  pps_stat_t stat,
    output pps_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_TAIL   = 5'b01000,
        S_COMMIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (stat.cnt_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.cnt_last) begin
                    state_next = S_TAIL;
                end
            end
            // last read data is evaluated here
            S_TAIL: begin
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

>>> rtl/core/pps_datapath.sv
// Datapath for the promotable priority store: slot memories, scan counter,
// free/match/max trackers, commit logic and the output register.
// Depends on pps_pkg.
module pps_datapath
    import pps_pkg::*;
#(
    parameter int CAPACITY     = DEF_CAPACITY,
    parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS,
    parameter int IDENT_BITS   = DEF_IDENT_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  pps_cmd_t            cmd,
    output pps_stat_t           stat,
    input  logic [KIND_W-1:0]   s_kind,
    input  logic [FIELD_W-1:0]  s_entry_id,
    input  logic [FIELD_W-1:0]  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic                m_found,
    output logic [FIELD_W-1:0]  m_result_id,
    output logic [FIELD_W-1:0]  m_result_payload,
    output logic [FIELD_W-1:0]  m_result_priority
);

    localparam int CNT_W = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAPACITY - 1);

    // Slot memories
    logic                    used_mem  [CAPACITY];
    logic [IDENT_BITS-1:0]   ident_mem [CAPACITY];
    logic [PAYLOAD_BITS-1:0] data_mem  [CAPACITY];
    logic [RANK_BITS-1:0]    rank_mem  [CAPACITY];

    logic [CNT_W-1:0]        cnt_reg;
    logic [IDENT_BITS-1:0]   next_ident_reg;

    // Captured item
    logic [KIND_W-1:0]       kind_reg;
    logic [IDENT_BITS-1:0]   id_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg;

    // Registered read data
    logic                    eval_vld_reg;
    logic [CNT_W-1:0]        eval_idx_reg;
    logic                    used_q;
    logic [IDENT_BITS-1:0]   ident_q;
    logic [PAYLOAD_BITS-1:0] data_q;
    logic [RANK_BITS-1:0]    rank_q;

    // Scan trackers
    logic                    free_found_reg;
    logic [CNT_W-1:0]        free_idx_reg;
    logic                    hit_found_reg;
    logic [CNT_W-1:0]        hit_idx_reg;
    logic [IDENT_BITS-1:0]   hit_ident_reg;
    logic [PAYLOAD_BITS-1:0] hit_data_reg;
    logic [RANK_BITS-1:0]    hit_rank_reg;
    logic                    best_found_reg;
    logic [CNT_W-1:0]        best_idx_reg;
    logic [IDENT_BITS-1:0]   best_ident_reg;
    logic [PAYLOAD_BITS-1:0] best_data_reg;
    logic [RANK_BITS-1:0]    best_rank_reg;

    // Output register
    logic                    m_valid_reg;
    logic [STATUS_W-1:0]     status_reg;
    logic                    found_reg;
    logic [FIELD_W-1:0]      res_id_reg;
    logic [FIELD_W-1:0]      res_payload_reg;
    logic [FIELD_W-1:0]      res_rank_reg;

    // Commit-side signals
    logic                    used_we;
    logic [CNT_W-1:0]        used_waddr;
    logic                    used_wdata;
    logic                    ent_we;
    logic [CNT_W-1:0]        ent_waddr;
    logic [IDENT_BITS-1:0]   ent_ident;
    logic [PAYLOAD_BITS-1:0] ent_data;
    logic [RANK_BITS-1:0]    ent_rank;
    logic                    adv_ident;
    logic [STATUS_W-1:0]     res_status;
    logic                    rep_on;
    logic [IDENT_BITS-1:0]   rep_ident;
    logic [PAYLOAD_BITS-1:0] rep_data;
    logic [RANK_BITS-1:0]    rep_rank;
    logic [RANK_BITS-1:0]    promo_rank;
    logic [63:0]             rep_ident_wide;
    logic [63:0]             rep_data_wide;
    logic                    beats_best;

    assign stat.cnt_last = (cnt_reg == CNT_LAST);
    assign stat.out_free = !m_valid_reg || m_ready;

    // Slot counter, shared by the clearing pass and the scan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.load) begin
            cnt_reg <= '0;
        end else if (cmd.clear_step || cmd.scan_step) begin
            cnt_reg <= stat.cnt_last ? '0 : cnt_reg + CNT_W'(1);
        end
    end

    // Capture the item
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg    <= s_kind;
            id_reg      <= IDENT_BITS'(s_entry_id);
            payload_reg <= PAYLOAD_BITS'(s_payload);
        end
    end

    // Used-bit memory: cleared by the pass after reset
    always_ff @(posedge aclk) begin
        if (used_we) begin
            used_mem[used_waddr] <= used_wdata;
        end
        if (cmd.scan_step) begin
            used_q <= used_mem[cnt_reg];
        end
    end

    // Entry memories
    always_ff @(posedge aclk) begin
        if (ent_we) begin
            ident_mem[ent_waddr] <= ent_ident;
            data_mem[ent_waddr]  <= ent_data;
            rank_mem[ent_waddr]  <= ent_rank;
        end
        if (cmd.scan_step) begin
            ident_q <= ident_mem[cnt_reg];
            data_q  <= data_mem[cnt_reg];
            rank_q  <= rank_mem[cnt_reg];
        end
    end

    // Read data tag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eval_vld_reg <= 1'b0;
        end else begin
            eval_vld_reg <= cmd.scan_step;
        end
        eval_idx_reg <= cnt_reg;
    end

    // Higher rank wins, then larger ident; exact tie keeps the lower slot
    assign beats_best = !best_found_reg || (rank_q > best_rank_reg) ||
                        ((rank_q == best_rank_reg) && (ident_q > best_ident_reg));

    // Scan trackers
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.load) begin
            free_found_reg <= 1'b0;
            hit_found_reg  <= 1'b0;
            best_found_reg <= 1'b0;
        end else if (eval_vld_reg) begin
            if (!used_q && !free_found_reg) begin
                free_found_reg <= 1'b1;
            end
            if (used_q && ident_q == id_reg && !hit_found_reg) begin
                hit_found_reg <= 1'b1;
            end
            if (used_q && beats_best) begin
                best_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (eval_vld_reg) begin
            if (!used_q && !free_found_reg) begin
                free_idx_reg <= eval_idx_reg;
            end
            if (used_q && ident_q == id_reg && !hit_found_reg) begin
                hit_idx_reg   <= eval_idx_reg;
                hit_ident_reg <= ident_q;
                hit_data_reg  <= data_q;
                hit_rank_reg  <= rank_q;
            end
            if (used_q && beats_best) begin
                best_idx_reg   <= eval_idx_reg;
                best_ident_reg <= ident_q;
                best_data_reg  <= data_q;
                best_rank_reg  <= rank_q;
            end
        end
    end

    // Saturating promote
    assign promo_rank = (hit_rank_reg == '1) ? hit_rank_reg
                                             : hit_rank_reg + RANK_BITS'(1);

    // Commit decode and memory write selection
    always_comb begin
        used_we    = 1'b0;
        used_waddr = cnt_reg;
        used_wdata = 1'b0;
        ent_we     = 1'b0;
        ent_waddr  = hit_idx_reg;
        ent_ident  = hit_ident_reg;
        ent_data   = hit_data_reg;
        ent_rank   = promo_rank;
        adv_ident  = 1'b0;
        res_status = STAT_OK;
        rep_on     = 1'b0;
        rep_ident  = hit_ident_reg;
        rep_data   = hit_data_reg;
        rep_rank   = hit_rank_reg;

        case (kind_reg)
            KIND_ADD: begin
                if (!free_found_reg) begin
                    res_status = STAT_FULL;
                end else begin
                    used_we    = cmd.commit;
                    used_waddr = free_idx_reg;
                    used_wdata = 1'b1;
                    ent_we     = cmd.commit;
                    ent_waddr  = free_idx_reg;
                    ent_ident  = next_ident_reg;
                    ent_data   = payload_reg;
                    ent_rank   = '0;
                    adv_ident  = cmd.commit;
                    rep_on     = 1'b1;
                    rep_ident  = next_ident_reg;
                    rep_data   = payload_reg;
                    rep_rank   = '0;
                end
            end
            KIND_PROMOTE: begin
                if (!hit_found_reg) begin
                    res_status = STAT_UNKNOWN;
                end else begin
                    ent_we   = cmd.commit;
                    rep_on   = 1'b1;
                    rep_rank = promo_rank;
                end
            end
            KIND_GET_MAX, KIND_POP_MAX: begin
                if (!best_found_reg) begin
                    res_status = STAT_EMPTY;
                end else begin
                    rep_on    = 1'b1;
                    rep_ident = best_ident_reg;
                    rep_data  = best_data_reg;
                    rep_rank  = best_rank_reg;
                    if (kind_reg == KIND_POP_MAX) begin
                        used_we    = cmd.commit;
                        used_waddr = best_idx_reg;
                        used_wdata = 1'b0;
                    end
                end
            end
            KIND_IS_VALID: begin
                rep_on = hit_found_reg;
            end
            KIND_GET: begin
                if (!hit_found_reg) begin
                    res_status = STAT_UNKNOWN;
                end else begin
                    rep_on = 1'b1;
                end
            end
            default: begin
                res_status = STAT_OK;
            end
        endcase

        // clearing pass owns the used-bit port
        if (cmd.clear_step) begin
            used_we    = 1'b1;
            used_waddr = cnt_reg;
            used_wdata = 1'b0;
        end
    end

    assign rep_ident_wide = 64'(rep_ident);
    assign rep_data_wide  = 64'(rep_data);

    // Identifier counter, wraps at IDENT_BITS
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_ident_reg <= '0;
        end else if (adv_ident) begin
            next_ident_reg <= next_ident_reg + IDENT_BITS'(1);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            status_reg      <= res_status;
            found_reg       <= rep_on;
            res_id_reg      <= rep_on ? rep_ident_wide[FIELD_W-1:0] : '0;
            res_payload_reg <= rep_on ? rep_data_wide[FIELD_W-1:0] : '0;
            res_rank_reg    <= rep_on ? rep_rank : '0;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = status_reg;
    assign m_found           = found_reg;
    assign m_result_id       = res_id_reg;
    assign m_result_payload  = res_payload_reg;
    assign m_result_priority = res_rank_reg;

endmodule
